@@ rtl/core/skw_pkg.sv @@
// shared constants, keyword table and helpers for the sql keyword screen
`timescale 1ns / 1ps
package skw_pkg;

	localparam int KeywordCountDef = 8;
	localparam int KeywordMax      = 8;
	// earlier bytes kept after the brace; the current byte makes the eighth
	localparam int WindowDepth     = 7;
	localparam logic [7:0] BraceChar = 8'h7D;

	// byte j of each entry is the keyword character j places back from its end
	localparam logic [63:0] KwText [KeywordMax] = '{
		64'("UPDATE"),
		64'("DELETE"),
		64'("SHUTDOWN"),
		64'("SELECT"),
		64'("DATABASE"),
		64'("DROP"),
		64'("--"),
		64'("INSERT")
	};

	localparam int KwLen [KeywordMax] = '{6, 6, 8, 6, 8, 4, 2, 6};

	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/skw_if.sv @@
// item channels of the keyword screen: text bytes in, verdicts out
`timescale 1ns / 1ps
interface skw_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       is_final;

	modport source (output valid, output text_byte, output is_final, input ready);
	modport sink   (input valid, input text_byte, input is_final, output ready);
endinterface

interface skw_verdict_if;
	logic valid;
	logic ready;
	logic allowed;

	modport source (output valid, output allowed, input ready);
	modport sink   (input valid, input allowed, output ready);
endinterface

@@ rtl/core/skw_cell.sv @@
// one window cell: holds a folded byte and compares it to its place in every keyword
`timescale 1ns / 1ps
module skw_cell #(
	parameter int KEYWORD_COUNT = skw_pkg::KeywordCountDef,
	parameter int CellIndex     = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     shift,
	input  logic                     clear,
	input  logic [7:0]               byte_in,
	input  logic                     valid_in,
	output logic [7:0]               byte_out,
	output logic                     valid_out,
	output logic [KEYWORD_COUNT-1:0] eq
);

	// this cell holds the byte CellIndex+1 places back from the current one
	localparam int Back = CellIndex + 1;

	logic [7:0] byte_q;
	logic       valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	for (genvar i = 0; i < KEYWORD_COUNT; i++) begin : g_kw
		if (Back >= skw_pkg::KwLen[i]) begin : g_beyond
			assign eq[i] = 1'b1;
		end else begin : g_cmp
			assign eq[i] = valid_q && (byte_q == skw_pkg::KwText[i][8*Back +: 8]);
		end
	end

	assign byte_out  = byte_q;
	assign valid_out = valid_q;

endmodule

@@ rtl/core/skw_out_buf.sv @@
// two-entry verdict buffer: output register plus skid stage
`timescale 1ns / 1ps
module skw_out_buf (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic push_allowed,
	output logic can_push,
	skw_verdict_if.source verdict
);

	logic out_valid_q;
	logic out_allowed_q;
	logic skid_valid_q;
	logic skid_allowed_q;
	logic take;

	assign take     = out_valid_q && verdict.ready;
	assign can_push = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_allowed_q <= skid_allowed_q;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_allowed_q <= push_allowed;
			end else begin
				skid_allowed_q <= push_allowed;
			end
		end
	end

	assign verdict.valid   = out_valid_q;
	assign verdict.allowed = out_allowed_q;

endmodule

@@ rtl/core/sql_keyword_screen.sv @@
// top level of the sql keyword screen: brace tracking, cell row and verdict
`timescale 1ns / 1ps
// Screens a text for SQL keywords that follow its first closing brace.
// text channel: one byte per item, is_final marks the last byte of a text.
// verdict channel: one item per text, sent for the byte marked final;
// allowed is 0 when UPDATE, DELETE, SHUTDOWN, SELECT, DATABASE, DROP, "--"
// or INSERT (the first KEYWORD_COUNT of these) lies wholly after the brace.
// Bytes after the brace are folded to upper case and shifted through a row
// of seven cells; each cell checks its byte at its place in each keyword
// and the current byte completes the eight-byte window in the same cycle.
// Throughput: one byte per cycle while ready is high (skid stage empty).
// The verdict is registered in the output register, or in the skid stage.
// When the receiver stalls, one verdict waits in the output register and a
// second in a skid stage; text bytes keep flowing until the skid is full,
// then ready drops until the receiver takes a verdict.
// Reset clears the brace flag, the keyword flag, the cell valid bits and the
// verdict buffer; each verdict also clears the text state for the next text.
module sql_keyword_screen #(
	parameter int KEYWORD_COUNT = skw_pkg::KeywordCountDef
) (
	input  logic clk,
	input  logic arst_n,
	skw_text_if.sink      text,
	skw_verdict_if.source verdict
);

	localparam int Depth = skw_pkg::WindowDepth;

	logic                     accept;
	logic                     can_push;
	logic                     past_brace_q;
	logic                     hit_q;
	logic [7:0]               folded;
	logic                     shift;
	logic                     clear;
	logic                     match_now;
	logic [KEYWORD_COUNT-1:0] kw_match;

	logic [7:0]               cell_byte  [Depth];
	logic                     cell_valid [Depth];
	logic [KEYWORD_COUNT-1:0] cell_eq    [Depth];

	assign text.ready = can_push;
	assign accept     = text.valid && text.ready;
	assign folded     = skw_pkg::fold_upper(text.text_byte);
	assign shift      = accept && past_brace_q;
	// the first brace empties the window; the final byte ends the text
	assign clear      = accept && (text.is_final || (!past_brace_q &&
		text.text_byte == skw_pkg::BraceChar));

	for (genvar k = 0; k < Depth; k++) begin : g_cell
		if (k == 0) begin : g_head
			skw_cell #(.KEYWORD_COUNT(KEYWORD_COUNT), .CellIndex(k)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (shift),
				.clear    (clear),
				.byte_in  (folded),
				.valid_in (1'b1),
				.byte_out (cell_byte[k]),
				.valid_out(cell_valid[k]),
				.eq       (cell_eq[k])
			);
		end else begin : g_body
			skw_cell #(.KEYWORD_COUNT(KEYWORD_COUNT), .CellIndex(k)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (shift),
				.clear    (clear),
				.byte_in  (cell_byte[k-1]),
				.valid_in (cell_valid[k-1]),
				.byte_out (cell_byte[k]),
				.valid_out(cell_valid[k]),
				.eq       (cell_eq[k])
			);
		end
	end

	always_comb begin
		for (int i = 0; i < KEYWORD_COUNT; i++) begin
			kw_match[i] = (folded == skw_pkg::KwText[i][7:0]);
			for (int k = 0; k < Depth; k++) begin
				kw_match[i] = kw_match[i] & cell_eq[k][i];
			end
		end
	end

	assign match_now = past_brace_q && (|kw_match);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			past_brace_q <= 1'b0;
			hit_q        <= 1'b0;
		end else if (accept) begin
			if (text.is_final) begin
				past_brace_q <= 1'b0;
				hit_q        <= 1'b0;
			end else begin
				if (!past_brace_q && text.text_byte == skw_pkg::BraceChar) begin
					past_brace_q <= 1'b1;
				end
				if (match_now) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	skw_out_buf u_out_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (accept && text.is_final),
		.push_allowed(!(hit_q || match_now)),
		.can_push    (can_push),
		.verdict     (verdict)
	);

endmodule
